/* hw/rtl/sfsp_pkg.sv */
// Shared types, constants and the CRC byte step of the frame stream parser.
`default_nettype none

package sfsp_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 256;
    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int HEADER_BYTES      = 6;
    localparam int CNT_NUM           = 7;
    localparam int CNT_SEL_W         = $clog2(CNT_NUM);
    localparam int READ_W            = 32;

    localparam logic [2:0]  HDR_LAST     = 3'(HEADER_BYTES - 1);
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [7:0]  SOF_FIRST_RST = 8'hAA;
    localparam logic [7:0]  SOF_SECOND_RST = 8'h55;
    localparam logic [7:0]  VERSION_RST  = 8'h01;
    localparam logic [8:0]  LIMIT_RST    = 9'd256;

    localparam int CNT_BYTES  = 0;
    localparam int CNT_OK     = 1;
    localparam int CNT_SOF    = 2;
    localparam int CNT_LEN    = 3;
    localparam int CNT_VER    = 4;
    localparam int CNT_CRC    = 5;
    localparam int CNT_RESYNC = 6;

    typedef enum logic [1:0] {
        CMD_FEED         = 2'd0,
        CMD_READ_PAYLOAD = 2'd1,
        CMD_READ_COUNTER = 2'd2,
        CMD_RESYNC       = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_FRAME_READY = 3'd1,
        EV_BAD_LENGTH  = 3'd2,
        EV_BAD_VERSION = 3'd3,
        EV_BAD_CRC     = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4
    } phase_t;

    typedef enum logic [7:0] {
        REG_SOF_FIRST  = 8'd0,
        REG_SOF_SECOND = 8'd1,
        REG_VERSION    = 8'd2,
        REG_LIMIT      = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] version;
        logic [7:0] kind;
        logic [7:0] seq_num;
        logic [7:0] command;
        logic [8:0] length;
    } frame_hdr_t;

    typedef struct packed {
        event_t            event_res;
        logic              frame_valid;
        frame_hdr_t        hdr;
        logic              payload_read;
        logic [READ_W-1:0] read_value;
    } stage_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/sfsp_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module sfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/sfsp_counters.sv */
// Wrapping event counters with a selectable read.
`default_nettype none

module sfsp_counters #(
    parameter int COUNTER_WIDTH = sfsp_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [sfsp_pkg::CNT_NUM-1:0] inc,
    input  wire logic [7:0]                   sel,
    output logic      [sfsp_pkg::READ_W-1:0]  value
);

    logic [COUNTER_WIDTH-1:0] cnt_reg [sfsp_pkg::CNT_NUM];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < sfsp_pkg::CNT_NUM; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < sfsp_pkg::CNT_NUM; i++) begin
                cnt_reg[i] <= cnt_reg[i] + {{(COUNTER_WIDTH-1){1'b0}}, inc[i]};
            end
        end
    end

    always_comb begin
        if (sel < 8'(sfsp_pkg::CNT_NUM)) begin
            value = sfsp_pkg::READ_W'(cnt_reg[sel[sfsp_pkg::CNT_SEL_W-1:0]]);
        end else begin
            value = '0;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sfsp_parser.sv */
// Frame parser state, configuration registers and per-item next-state logic.
`default_nettype none

module sfsp_parser #(
    parameter int PAYLOAD_DEPTH = sfsp_pkg::PAYLOAD_DEPTH_DEF,
    parameter int COUNTER_WIDTH = sfsp_pkg::COUNTER_WIDTH_DEF,
    localparam int PAW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire sfsp_pkg::cmd_t        cmd,
    input  wire logic [7:0]            data_byte,
    input  wire logic [7:0]            index,
    input  wire logic                  cfg_valid,
    input  wire logic [7:0]            cfg_index,
    input  wire logic [8:0]            cfg_data,
    output sfsp_pkg::stage_t           stage_next,
    output logic                       wr_en,
    output logic [PAW:0]               wr_addr,
    output logic [7:0]                 wr_data,
    output logic                       rd_en,
    output logic [PAW:0]               rd_addr
);

    localparam int LEN_W = $clog2(PAYLOAD_DEPTH + 1);
    localparam logic [15:0] MAX16 = 16'(PAYLOAD_DEPTH);

    logic [7:0] sof_first_reg;
    logic [7:0] sof_second_reg;
    logic [7:0] version_reg;
    logic [8:0] limit_reg;

    sfsp_pkg::phase_t     phase_reg, phase_next;
    logic [7:0]           hdr_reg [sfsp_pkg::HEADER_BYTES];
    logic [7:0]           hdr_next [sfsp_pkg::HEADER_BYTES];
    logic [2:0]           hcount_reg, hcount_next;
    logic [LEN_W-1:0]     pcount_reg, pcount_next;
    logic [LEN_W-1:0]     exp_len_reg, exp_len_next;
    logic [7:0]           crc_lo_reg, crc_lo_next;
    logic                 crc_half_reg, crc_half_next;
    logic [15:0]          crc_reg, crc_next;
    sfsp_pkg::frame_hdr_t fhdr_reg, fhdr_next;
    logic                 ready_reg, ready_next;
    logic                 bank_reg, bank_next;

    logic [sfsp_pkg::CNT_NUM-1:0] inc;
    logic [sfsp_pkg::READ_W-1:0]  cnt_value;
    sfsp_pkg::event_t             ev;
    logic [15:0]                  crc_byte;
    logic [15:0]                  rx_len;
    logic [15:0]                  limit16;

    sfsp_counters #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_counters (
        .aclk   (aclk),
        .aresetn(aresetn),
        .inc    (inc),
        .sel    (index),
        .value  (cnt_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sof_first_reg  <= sfsp_pkg::SOF_FIRST_RST;
            sof_second_reg <= sfsp_pkg::SOF_SECOND_RST;
            version_reg    <= sfsp_pkg::VERSION_RST;
            limit_reg      <= sfsp_pkg::LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sfsp_pkg::REG_SOF_FIRST:  sof_first_reg  <= cfg_data[7:0];
                sfsp_pkg::REG_SOF_SECOND: sof_second_reg <= cfg_data[7:0];
                sfsp_pkg::REG_VERSION:    version_reg    <= cfg_data[7:0];
                sfsp_pkg::REG_LIMIT:      limit_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= sfsp_pkg::PH_FIRST;
            for (int i = 0; i < sfsp_pkg::HEADER_BYTES; i++) begin
                hdr_reg[i] <= '0;
            end
            hcount_reg   <= '0;
            pcount_reg   <= '0;
            exp_len_reg  <= '0;
            crc_lo_reg   <= '0;
            crc_half_reg <= 1'b0;
            crc_reg      <= sfsp_pkg::CRC_INIT;
            fhdr_reg     <= '0;
            ready_reg    <= 1'b0;
            bank_reg     <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            hdr_reg      <= hdr_next;
            hcount_reg   <= hcount_next;
            pcount_reg   <= pcount_next;
            exp_len_reg  <= exp_len_next;
            crc_lo_reg   <= crc_lo_next;
            crc_half_reg <= crc_half_next;
            crc_reg      <= crc_next;
            fhdr_reg     <= fhdr_next;
            ready_reg    <= ready_next;
            bank_reg     <= bank_next;
        end
    end

    assign crc_byte = sfsp_pkg::crc16_byte(crc_reg, data_byte);
    assign rx_len   = {data_byte, hdr_reg[4]};
    assign limit16  = ({7'd0, limit_reg} < MAX16) ? {7'd0, limit_reg} : MAX16;

    always_comb begin
        phase_next    = phase_reg;
        hdr_next      = hdr_reg;
        hcount_next   = hcount_reg;
        pcount_next   = pcount_reg;
        exp_len_next  = exp_len_reg;
        crc_lo_next   = crc_lo_reg;
        crc_half_next = crc_half_reg;
        crc_next      = crc_reg;
        fhdr_next     = fhdr_reg;
        ready_next    = ready_reg;
        bank_next     = bank_reg;
        inc           = '0;
        ev            = sfsp_pkg::EV_NONE;
        wr_en         = 1'b0;
        if (accept) begin
            unique case (cmd)
                sfsp_pkg::CMD_FEED: begin
                    inc[sfsp_pkg::CNT_BYTES] = 1'b1;
                    ready_next = 1'b0;
                    unique case (phase_reg)
                        sfsp_pkg::PH_FIRST: begin
                            if (data_byte == sof_first_reg) begin
                                phase_next = sfsp_pkg::PH_SECOND;
                            end else begin
                                inc[sfsp_pkg::CNT_SOF] = 1'b1;
                            end
                        end
                        sfsp_pkg::PH_SECOND: begin
                            if (data_byte == sof_second_reg) begin
                                hcount_next   = '0;
                                pcount_next   = '0;
                                crc_half_next = 1'b0;
                                crc_next      = sfsp_pkg::CRC_INIT;
                                phase_next    = sfsp_pkg::PH_HEADER;
                            end else begin
                                inc[sfsp_pkg::CNT_SOF]    = 1'b1;
                                inc[sfsp_pkg::CNT_RESYNC] = 1'b1;
                                if (data_byte != sof_first_reg) begin
                                    phase_next = sfsp_pkg::PH_FIRST;
                                end
                            end
                        end
                        sfsp_pkg::PH_HEADER: begin
                            hdr_next[hcount_reg] = data_byte;
                            hcount_next = hcount_reg + 3'd1;
                            crc_next    = crc_byte;
                            if (hcount_reg == sfsp_pkg::HDR_LAST) begin
                                priority if (rx_len > limit16) begin
                                    inc[sfsp_pkg::CNT_LEN]    = 1'b1;
                                    inc[sfsp_pkg::CNT_RESYNC] = 1'b1;
                                    phase_next = sfsp_pkg::PH_FIRST;
                                    ev         = sfsp_pkg::EV_BAD_LENGTH;
                                end else if (hdr_reg[0] != version_reg) begin
                                    inc[sfsp_pkg::CNT_VER]    = 1'b1;
                                    inc[sfsp_pkg::CNT_RESYNC] = 1'b1;
                                    phase_next = sfsp_pkg::PH_FIRST;
                                    ev         = sfsp_pkg::EV_BAD_VERSION;
                                end else begin
                                    exp_len_next = LEN_W'(rx_len);
                                    pcount_next  = '0;
                                    phase_next   = (rx_len == 16'd0) ? sfsp_pkg::PH_CRC
                                                                     : sfsp_pkg::PH_PAYLOAD;
                                end
                            end
                        end
                        sfsp_pkg::PH_PAYLOAD: begin
                            wr_en       = 1'b1;
                            pcount_next = pcount_reg + LEN_W'(1);
                            crc_next    = crc_byte;
                            if (pcount_next >= exp_len_reg) begin
                                phase_next = sfsp_pkg::PH_CRC;
                            end
                        end
                        sfsp_pkg::PH_CRC: begin
                            if (!crc_half_reg) begin
                                crc_lo_next   = data_byte;
                                crc_half_next = 1'b1;
                            end else begin
                                crc_half_next = 1'b0;
                                phase_next    = sfsp_pkg::PH_FIRST;
                                if ({data_byte, crc_lo_reg} != crc_reg) begin
                                    inc[sfsp_pkg::CNT_CRC]    = 1'b1;
                                    inc[sfsp_pkg::CNT_RESYNC] = 1'b1;
                                    ev = sfsp_pkg::EV_BAD_CRC;
                                end else begin
                                    fhdr_next.version  = hdr_reg[0];
                                    fhdr_next.kind     = hdr_reg[1];
                                    fhdr_next.seq_num  = hdr_reg[2];
                                    fhdr_next.command  = hdr_reg[3];
                                    fhdr_next.length   = 9'(exp_len_reg);
                                    ready_next = 1'b1;
                                    bank_next  = ~bank_reg;
                                    inc[sfsp_pkg::CNT_OK] = 1'b1;
                                    ev = sfsp_pkg::EV_FRAME_READY;
                                end
                            end
                        end
                        default: begin
                            phase_next = sfsp_pkg::PH_FIRST;
                        end
                    endcase
                end
                sfsp_pkg::CMD_READ_PAYLOAD: ;
                sfsp_pkg::CMD_READ_COUNTER: ;
                sfsp_pkg::CMD_RESYNC: begin
                    phase_next    = sfsp_pkg::PH_FIRST;
                    for (int i = 0; i < sfsp_pkg::HEADER_BYTES; i++) begin
                        hdr_next[i] = '0;
                    end
                    hcount_next   = '0;
                    pcount_next   = '0;
                    exp_len_next  = '0;
                    crc_lo_next   = '0;
                    crc_half_next = 1'b0;
                    crc_next      = sfsp_pkg::CRC_INIT;
                    fhdr_next     = '0;
                    ready_next    = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Receive into the idle bank, read the latched frame from the live bank.
    assign wr_addr = {~bank_reg, PAW'(pcount_reg)};
    assign wr_data = data_byte;
    assign rd_en   = accept;
    assign rd_addr = {bank_reg, PAW'(index)};

    always_comb begin
        stage_next.event_res    = ev;
        stage_next.frame_valid  = ready_next;
        stage_next.hdr          = fhdr_next;
        stage_next.payload_read = (cmd == sfsp_pkg::CMD_READ_PAYLOAD)
                                  && ({1'b0, index} < fhdr_reg.length)
                                  && ({24'd0, index} < 32'(PAYLOAD_DEPTH));
        stage_next.read_value   = (cmd == sfsp_pkg::CMD_READ_COUNTER) ? cnt_value : '0;
    end

endmodule

`default_nettype wire

/* hw/rtl/sof_frame_stream_parser_unit.sv */
// Top level of the start-of-frame stream parser: channels, payload RAM, result registers.
//
//  channel | direction | handshake             | contents
//  s_      | in        | s_tvalid / s_tready   | s_tuser cmd, s_tdata data_byte, index
//  m_      | out       | m_tvalid / m_tready   | m_tdata event, frame header, read value
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index register, cfg_data value
//
// One item per cycle while m_ is not stalled; each result passes the registered read of the
// payload RAM and the stage register alongside it, followed by the output register.
// Good frames swap the two payload banks, so latching a frame needs no copy of the payload.
// aresetn is synchronous; counters, registers and parser state reset, the RAM does not.
// A stalled m_ side holds one result in the output and one in the stage before it.
`default_nettype none

module sof_frame_stream_parser_unit #(
    parameter int PAYLOAD_DEPTH = sfsp_pkg::PAYLOAD_DEPTH_DEF,
    parameter int COUNTER_WIDTH = sfsp_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] index
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [79:0] m_tdata,   // [2:0] event_res, [3] frame_valid,
                                        // [11:4] frame_version, [19:12] frame_kind,
                                        // [27:20] frame_sequence, [35:28] frame_command,
                                        // [44:36] frame_length, [76:45] read_value, rest 0
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    localparam int PAW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    logic             accept;
    sfsp_pkg::stage_t stage_next;
    sfsp_pkg::stage_t p1_reg;
    logic             p1_valid_reg;
    logic             p1_move;
    logic             m_tvalid_reg;
    logic [79:0]      m_tdata_reg;
    logic             wr_en;
    logic [PAW:0]     wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [PAW:0]     rd_addr;
    logic [7:0]       rd_data;
    logic [31:0]      read_value;

    assign p1_move   = p1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !p1_valid_reg || p1_move;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    sfsp_parser #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .cmd       (sfsp_pkg::cmd_t'(s_tuser)),
        .data_byte (s_tdata[7:0]),
        .index     (s_tdata[15:8]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stage_next(stage_next),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    sfsp_ram #(
        .WIDTH(8),
        .DEPTH(2 ** (PAW + 1))
    ) u_payload_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_move) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg <= stage_next;
        end
    end

    assign read_value = p1_reg.payload_read ? {24'd0, rd_data} : p1_reg.read_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (p1_move) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            m_tdata_reg <= {3'd0, read_value, p1_reg.hdr.length, p1_reg.hdr.command,
                            p1_reg.hdr.seq_num, p1_reg.hdr.kind, p1_reg.hdr.version,
                            p1_reg.frame_valid, p1_reg.event_res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
